// ----- rtl/n2rgb_pkg.sv -----
// shared constants, item types and helper functions for the nv21 to rgb converter
// no dependencies; imported by every module of the block
package n2rgb_pkg;

  // frame geometry
  localparam int MAX_DIM = 4096;
  localparam int DIM_W   = $clog2(MAX_DIM);

  // configuration port
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LINES = CFG_IDX_W'(1);
  localparam logic [CFG_W-1:0] LINE_WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] FRAME_LINES_RESET = CFG_W'(480);
  localparam logic [CFG_W-1:0] LINE_WIDTH_MIN    = CFG_W'(2);
  localparam logic [CFG_W-1:0] FRAME_LINES_MIN   = CFG_W'(1);

  // pixel arithmetic
  localparam int PIX_W  = 8;
  localparam int CHR_W  = 8;
  localparam int FRAC_W = 10;
  localparam int ACC_W  = 21;

  localparam logic signed [ACC_W-1:0] COEF_CR_R = ACC_W'(1437);
  localparam logic signed [ACC_W-1:0] COEF_CB_G = ACC_W'(455);
  localparam logic signed [ACC_W-1:0] COEF_CR_G = ACC_W'(731);
  localparam logic signed [ACC_W-1:0] COEF_CB_B = ACC_W'(1814);

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [PIX_W-1:0]        luma;
    logic signed [CHR_W-1:0] cr;
    logic signed [CHR_W-1:0] cb;
    logic                    line_end;
    logic                    frame_end;
  } n2rgb_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] line_width;
    logic [CFG_W-1:0] frame_lines;
  } n2rgb_cfg_t;

  // clamp a dimension register into lo..MAX_DIM
  function automatic logic [CFG_W-1:0] sat_dim(input logic [CFG_W-1:0] v,
                                               input logic [CFG_W-1:0] lo);
    logic [CFG_W-1:0] r;
    if (v < lo) r = lo;
    else if (v > CFG_W'(MAX_DIM)) r = CFG_W'(MAX_DIM);
    else r = v;
    return r;
  endfunction

  // unsigned byte less the chroma bias, as a signed byte
  function automatic logic signed [CHR_W-1:0] unbias(input logic [CHR_W-1:0] b);
    return {~b[CHR_W-1], b[CHR_W-2:0]};
  endfunction

  // q10 value floored and clamped to 0..255
  function automatic logic [PIX_W-1:0] to_pixel(input logic signed [ACC_W-1:0] acc);
    logic [PIX_W-1:0] p;
    if (acc[ACC_W-1]) p = '0;
    else if (|acc[ACC_W-2:FRAC_W+PIX_W]) p = '1;
    else p = acc[FRAC_W+PIX_W-1:FRAC_W];
    return p;
  endfunction

endpackage

// ----- rtl/nv21_pixel_to_rgb_unit.sv -----
// nv21 pixel stream to rgb888 converter, top level
// an accepted item passes through its queue entry, the product stage register and the output register
// throughput: one item per cycle; the input stalls only once the four-item queue fills
// behind a stalled output
// reset (rst, synchronous): counters and held chroma cleared, line width 640, 480 lines per frame
// depends on n2rgb_pkg, n2rgb_front, n2rgb_queue, n2rgb_back
module nv21_pixel_to_rgb_unit import n2rgb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // pixel input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     luma,
  input  logic [CHR_W-1:0]     chroma_v,
  input  logic [CHR_W-1:0]     chroma_u,
  // rgb output
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PIX_W-1:0]     red,
  output logic [PIX_W-1:0]     green,
  output logic [PIX_W-1:0]     blue,
  output logic                 line_end,
  output logic                 frame_end
);

  logic        q_full;
  logic        accept;
  n2rgb_item_t front_item;
  logic        head_valid;
  n2rgb_item_t head_item;
  logic        pop;

  // the input side only waits when the queue is full, so the back part
  // can stall on its own without holding the front counters back
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // front: register writes, column and row tracking, chroma latch on even columns
  n2rgb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .luma      (luma),
    .chroma_v  (chroma_v),
    .chroma_u  (chroma_u),
    .item      (front_item)
  );

  // classified items wait here; a full queue pushes back on the input
  n2rgb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_item  (front_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // back: q10 colour matrix, floor and clamp, output register
  n2rgb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .line_end   (line_end),
    .frame_end  (frame_end)
  );

endmodule

// ----- rtl/n2rgb_front.sv -----
// front part: configuration registers, raster counters and chroma hold
// depends on n2rgb_pkg
module n2rgb_front import n2rgb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 accept,
  input  logic [PIX_W-1:0]     luma,
  input  logic [CHR_W-1:0]     chroma_v,
  input  logic [CHR_W-1:0]     chroma_u,
  output n2rgb_item_t          item
);

  n2rgb_cfg_t              cfg;
  logic [DIM_W-1:0]        column_count;
  logic [DIM_W-1:0]        row_count;
  logic signed [CHR_W-1:0] held_cr;
  logic signed [CHR_W-1:0] held_cb;

  logic [CFG_W-1:0]        w_last;
  logic [CFG_W-1:0]        h_last;
  logic                    even_col;
  logic                    lend;
  logic                    fend;
  logic signed [CHR_W-1:0] cr_now;
  logic signed [CHR_W-1:0] cb_now;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_width  <= LINE_WIDTH_RESET;
      cfg.frame_lines <= FRAME_LINES_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_LINE_WIDTH) cfg.line_width <= cfg_data;
      if (cfg_index == REG_FRAME_LINES) cfg.frame_lines <= cfg_data;
    end
  end

  always_comb begin
    w_last   = sat_dim(cfg.line_width, LINE_WIDTH_MIN) - CFG_W'(1);
    h_last   = sat_dim(cfg.frame_lines, FRAME_LINES_MIN) - CFG_W'(1);
    even_col = ~column_count[0];
    lend     = CFG_W'(column_count) >= w_last;
    fend     = lend && (CFG_W'(row_count) >= h_last);
    cr_now   = even_col ? unbias(chroma_v) : held_cr;
    cb_now   = even_col ? unbias(chroma_u) : held_cb;
    item.luma      = luma;
    item.cr        = cr_now;
    item.cb        = cb_now;
    item.line_end  = lend;
    item.frame_end = fend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      held_cr      <= '0;
      held_cb      <= '0;
    end else if (accept) begin
      held_cr <= cr_now;
      held_cb <= cb_now;
      if (lend) begin
        column_count <= '0;
        if (fend) row_count <= '0;
        else row_count <= row_count + DIM_W'(1);
      end else begin
        column_count <= column_count + DIM_W'(1);
      end
    end
  end

endmodule

// ----- rtl/n2rgb_queue.sv -----
// short item queue decoupling the front part from the back part
// depends on n2rgb_pkg
module n2rgb_queue import n2rgb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  n2rgb_item_t push_item,
  output logic        full,
  input  logic        pop,
  output logic        head_valid,
  output n2rgb_item_t head_item
);

  n2rgb_item_t       slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full       = fill == (QPTR_W+1)'(QUEUE_DEPTH);
  assign head_valid = fill != '0;
  assign head_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop) fill <= fill + (QPTR_W+1)'(1);
      else if (pop && !push) fill <= fill - (QPTR_W+1)'(1);
    end
  end

endmodule

// ----- rtl/n2rgb_back.sv -----
// back part: two-stage colour matrix (products, then sums with clamp) and output register
// depends on n2rgb_pkg
module n2rgb_back import n2rgb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  n2rgb_item_t      head_item,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PIX_W-1:0] red,
  output logic [PIX_W-1:0] green,
  output logic [PIX_W-1:0] blue,
  output logic             line_end,
  output logic             frame_end
);

  logic                    s1_valid;
  logic [PIX_W-1:0]        s1_luma;
  logic signed [ACC_W-1:0] s1_p_r;
  logic signed [ACC_W-1:0] s1_p_gb;
  logic signed [ACC_W-1:0] s1_p_gr;
  logic signed [ACC_W-1:0] s1_p_b;
  logic                    s1_lend;
  logic                    s1_fend;

  logic                    s2_free;
  logic                    s1_free;
  logic signed [ACC_W-1:0] cr_ext;
  logic signed [ACC_W-1:0] cb_ext;
  logic signed [ACC_W-1:0] y_q;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_g;
  logic signed [ACC_W-1:0] acc_b;

  assign s2_free = !out_valid || !out_stall;
  assign s1_free = !s1_valid || s2_free;
  assign pop     = head_valid && s1_free;

  always_comb begin
    cr_ext = {{(ACC_W-CHR_W){head_item.cr[CHR_W-1]}}, head_item.cr};
    cb_ext = {{(ACC_W-CHR_W){head_item.cb[CHR_W-1]}}, head_item.cb};
    y_q    = {{(ACC_W-PIX_W-FRAC_W){1'b0}}, s1_luma, {FRAC_W{1'b0}}};
    acc_r  = y_q + s1_p_r;
    acc_g  = y_q - s1_p_gb - s1_p_gr;
    acc_b  = y_q + s1_p_b;
  end

  // stage one: constant products
  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_luma <= head_item.luma;
      s1_p_r  <= COEF_CR_R * cr_ext;
      s1_p_gb <= COEF_CB_G * cb_ext;
      s1_p_gr <= COEF_CR_G * cr_ext;
      s1_p_b  <= COEF_CB_B * cb_ext;
      s1_lend <= head_item.line_end;
      s1_fend <= head_item.frame_end;
    end
  end

  // stage two: sums, floor and clamp into the output register
  always_ff @(posedge clk) begin
    if (s2_free && s1_valid) begin
      red       <= to_pixel(acc_r);
      green     <= to_pixel(acc_g);
      blue      <= to_pixel(acc_b);
      line_end  <= s1_lend;
      frame_end <= s1_fend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free) s1_valid <= pop;
      if (s2_free) out_valid <= s1_valid;
    end
  end

endmodule

// ----- bench/tb_nv21_pixel_to_rgb_unit.sv -----
`timescale 1ns / 100ps
// self-checking bench for nv21_pixel_to_rgb_unit: q10 colour prediction, line and frame flags
// depends on n2rgb_pkg (port widths, register indexes) and the rtl of the converter
module tb_nv21_pixel_to_rgb_unit;
  import n2rgb_pkg::*;

  // cycles with no handshake at all before the run is declared hung
  localparam int QUIET_LIMIT   = 2000;
  // quiet cycles let pass after the last result, before a register write and at the end
  localparam int DRAIN_CYCLES  = 8;
  localparam int RANDOM_ITEMS  = 1530;
  localparam int MAX_GAP       = 19;
  // indexes the block has no register behind; writes to them must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  // expected-pixel store plus its own copy of the converter state
  class rgb_pixel_scoreboard;
    typedef struct {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic       lend;
      logic       fend;
    } rgb_px_t;

    rgb_px_t     expected_px[$];
    int unsigned width_reg;
    int unsigned height_reg;
    int unsigned col;
    int unsigned row;
    int          cr;
    int          cb;
    int          faults;

    function new();
      width_reg  = 640;
      height_reg = 480;
      col        = 0;
      row        = 0;
      cr         = 0;
      cb         = 0;
      faults     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_LINE_WIDTH) width_reg = data;
      else if (idx == REG_FRAME_LINES) height_reg = data;
    endfunction

    // floor of a q10 sum, clamped to a byte
    function logic [7:0] q10_to_byte(int acc);
      int q;
      if (acc < 0) return 8'd0;
      q = acc >>> 10;
      if (q > 255) return 8'd255;
      return q[7:0];
    endfunction

    function void note_pixel(logic [7:0] y, logic [7:0] v, logic [7:0] u);
      int unsigned w;
      int unsigned h;
      int          yq;
      rgb_px_t     px;
      w = (width_reg < 2) ? 2 : ((width_reg > MAX_DIM) ? MAX_DIM : width_reg);
      h = (height_reg < 1) ? 1 : ((height_reg > MAX_DIM) ? MAX_DIM : height_reg);
      // even columns take fresh chroma, odd ones reuse the held pair
      if (col[0] == 1'b0) begin
        cr = int'(v) - 128;
        cb = int'(u) - 128;
      end
      yq      = int'(y) * 1024;
      px.r    = q10_to_byte(yq + 1437 * cr);
      px.g    = q10_to_byte(yq - 455 * cb - 731 * cr);
      px.b    = q10_to_byte(yq + 1814 * cb);
      px.lend = (col >= w - 1);
      px.fend = 1'b0;
      if (px.lend) begin
        col     = 0;
        px.fend = (row >= h - 1);
        if (px.fend) row = 0;
        else row = row + 1;
      end else begin
        col = col + 1;
      end
      expected_px.push_back(px);
    endfunction

    function void report(string field, int exp_val, int act_val);
      faults++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val, act_val);
    endfunction

    function void check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                              logic lend, logic fend);
      rgb_px_t px;
      if (expected_px.size() == 0) begin
        faults++;
        $display("%0t: pixel out with none expected, expected nothing, actual %0d %0d %0d",
                 $time, r, g, b);
        return;
      end
      px = expected_px.pop_front();
      if (r !== px.r) report("red", px.r, r);
      if (g !== px.g) report("green", px.g, g);
      if (b !== px.b) report("blue", px.b, b);
      if (lend !== px.lend) report("line_end", px.lend, lend);
      if (fend !== px.fend) report("frame_end", px.fend, fend);
    endfunction

    function int outstanding();
      return expected_px.size();
    endfunction
  endclass

  typedef struct {
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
  } reg_write_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [PIX_W-1:0]     luma = '0;
  logic [CHR_W-1:0]     chroma_v = '0;
  logic [CHR_W-1:0]     chroma_u = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PIX_W-1:0]     red;
  logic [PIX_W-1:0]     green;
  logic [PIX_W-1:0]     blue;
  logic                 line_end;
  logic                 frame_end;

  rgb_pixel_scoreboard  sb;
  reg_write_t           reg_writes[$];
  int                   pixels_sent = 0;
  int                   quiet_cycles = 0;
  // per-phase switches that turn off idling on one side
  bit                   in_burst = 1'b0;
  bit                   out_burst = 1'b0;

  nv21_pixel_to_rgb_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .luma      (luma),
    .chroma_v  (chroma_v),
    .chroma_u  (chroma_u),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .line_end  (line_end),
    .frame_end (frame_end)
  );

  always #5 clk = ~clk;

  // result side: every accepted pixel goes to the scoreboard
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_pixel(red, green, blue, line_end, frame_end);
  end

  // hang detection: any handshake clears the count
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: draws a stall length before each pixel, none in burst phases
  initial begin : receiver
    int hold;
    do @(posedge clk); while (rst);
    forever begin
      hold = out_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // mostly random bytes, with a good share of the two extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one pixel: optional gap, then hold the item until the block takes it
  // leaves in_valid high so that a back-to-back item needs no second assignment
  task automatic send_pixel(input logic [7:0] y, input logic [7:0] v, input logic [7:0] u);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    luma     <= y;
    chroma_v <= v;
    chroma_u <= u;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(y, v, u);
    pixels_sent++;
  endtask

  // drop valid, wait for every outstanding pixel, then let the pipeline go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    reg_write_t wr;
    wr.idx  = idx;
    wr.data = data;
    reg_writes.push_back(wr);
  endtask

  // issue the queued register writes back to back, only ever while the block is idle
  task automatic flush_writes();
    reg_write_t wr;
    while (reg_writes.size() != 0) begin
      wr = reg_writes.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= wr.idx;
      cfg_data  <= wr.data;
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(wr.idx, wr.data);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int n;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset geometry: chroma extremes both ways, odd columns carry chroma that must be ignored
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'h80, 8'h80, 8'h80);
    send_pixel(8'hff, 8'h00, 8'hff);
    settle();

    // odd line width: the last column is even and latches fresh chroma; two-line frame
    queue_write(REG_LINE_WIDTH, CFG_W'(3));
    queue_write(REG_FRAME_LINES, CFG_W'(2));
    flush_writes();
    send_pixel(8'h10, 8'hff, 8'h00);
    send_pixel(8'h20, 8'h00, 8'hff);
    send_pixel(8'h30, 8'h00, 8'hff);
    send_pixel(8'hff, 8'h00, 8'h00);
    send_pixel(8'h00, 8'hff, 8'hff);
    send_pixel(8'h7f, 8'h81, 8'h7f);
    send_pixel(8'h01, 8'hfe, 8'h01);
    settle();

    // zero in both registers saturates to the smallest frame; spare indexes are ignored
    queue_write(REG_LINE_WIDTH, CFG_W'(0));
    queue_write(REG_FRAME_LINES, CFG_W'(0));
    queue_write(REG_SPARE_A, '1);
    queue_write(REG_SPARE_B, CFG_W'(5));
    flush_writes();
    send_pixel(8'hff, 8'h00, 8'h00);
    send_pixel(8'h00, 8'hff, 8'hff);
    send_pixel(8'h80, 8'h00, 8'hff);
    send_pixel(8'h80, 8'hff, 8'h00);
    settle();

    // all ones saturates to the largest dimension
    queue_write(REG_LINE_WIDTH, '1);
    queue_write(REG_FRAME_LINES, '1);
    flush_writes();
    send_pixel(8'h55, 8'haa, 8'h55);
    send_pixel(8'haa, 8'h55, 8'haa);
    send_pixel(8'hff, 8'hff, 8'h00);
    settle();

    // random phases: small frames mostly so line and frame ends are frequent,
    // phases stop anywhere so a new geometry often lands mid-line
    while (pixels_sent < RANDOM_ITEMS) begin
      in_burst  = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 7))
        0: begin
          queue_write(REG_LINE_WIDTH, CFG_W'($urandom_range(0, 8191)));
          queue_write(REG_FRAME_LINES, CFG_W'($urandom_range(0, 8191)));
        end
        1: queue_write(REG_LINE_WIDTH, CFG_W'($urandom_range(2, 12)));
        2: queue_write(REG_FRAME_LINES, CFG_W'($urandom_range(1, 5)));
        default: begin
          queue_write(REG_LINE_WIDTH, CFG_W'($urandom_range(2, 12)));
          queue_write(REG_FRAME_LINES, CFG_W'($urandom_range(1, 5)));
        end
      endcase
      if ($urandom_range(0, 9) == 0)
        queue_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                    CFG_W'($urandom_range(0, 8191)));
      flush_writes();
      n = $urandom_range(8, 48);
      repeat (n) send_pixel(pick_byte(), pick_byte(), pick_byte());
      settle();
    end

    if (sb.faults == 0 && sb.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
